// File: hdl/uf2bf_pkg.sv
package uf2bf_pkg;

   // Default number of image bytes carried in one block.
   localparam int unsigned DEF_PAYLOAD_BYTES = 256;

   localparam logic [31:0] SIG_START_A  = 32'h0A32_4655;
   localparam logic [31:0] SIG_START_B  = 32'h9E5D_5157;
   localparam logic [31:0] SIG_TRAILER  = 32'h0AB1_6F30;
   localparam logic [31:0] FLAG_FAMILY  = 32'h0000_2000;

   localparam int unsigned HEADER_BYTES = 32;
   // Byte position inside a 512-byte block and word index inside it.
   localparam int unsigned POS_W        = 9;
   localparam int unsigned WIDX_W       = 6;
   localparam logic [WIDX_W-1:0] LAST_WIDX = 6'd63;
   localparam int unsigned BLKNUM_W     = 24;

   localparam int unsigned QUEUE_DEPTH  = 4;

   localparam int unsigned CSR_ADDR_W   = 4;
   localparam int unsigned REG_IDX_W    = 2;
   localparam logic [REG_IDX_W-1:0] REG_FAMILY = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BASE   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_TOTAL  = 2'd2;

   // One accepted byte together with what the back end must do around it.
   typedef struct packed {
      logic [7:0]          data;
      logic                hdr;
      logic                pad;
      logic                last;
      logic [POS_W-1:0]    pos;
      logic [BLKNUM_W-1:0] blk;
      logic [31:0]         addr;
   } cmd_type;

endpackage

// File: hdl/uf2bf_blkcnt.sv
module uf2bf_blkcnt #(
   parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::DEF_PAYLOAD_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [31:0] total_bytes,
   output logic        busy,
   output logic [31:0] block_count
);
   import uf2bf_pkg::*;

   localparam int unsigned FRAC_W = 33;
   // Reciprocal of the payload size scaled by 2^33, rounded down.
   localparam logic [31:0] RECIP  = 32'((64'd1 << FRAC_W) / 64'(PAYLOAD_BYTES));
   localparam logic [2:0]  STEPS  = 3'd4;

   logic [32:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [30:0] q0_ff, q0_in;
   logic [32:0] rem_ff, rem_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] nblk_ff, nblk_in;
   logic [39:0] qp;

   // The block count is (total + size - 1) / size. The scaled reciprocal gives a
   // quotient that is low by at most one, and the remainder check puts it back.
   always_comb begin
      x_in    = x_ff;
      prod_in = prod_ff;
      q0_in   = q0_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      nblk_in = nblk_ff;
      qp      = 40'(q0_ff) * 40'(PAYLOAD_BYTES);
      if (load) begin
         x_in   = {1'b0, total_bytes} + 33'(PAYLOAD_BYTES - 1);
         cnt_in = STEPS;
      end else if (cnt_ff == 3'd4) begin
         prod_in = 64'(x_ff[31:0]) * 64'(RECIP) + (x_ff[32] ? {RECIP, 32'd0} : 64'd0);
         cnt_in  = cnt_ff - 3'd1;
      end else if (cnt_ff == 3'd3) begin
         q0_in  = prod_ff[63:33];
         cnt_in = cnt_ff - 3'd1;
      end else if (cnt_ff == 3'd2) begin
         rem_in = x_ff - qp[32:0];
         cnt_in = cnt_ff - 3'd1;
      end else if (cnt_ff == 3'd1) begin
         nblk_in = 32'(q0_ff) + 32'(rem_ff >= 33'(PAYLOAD_BYTES));
         cnt_in  = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         nblk_ff <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         nblk_ff <= nblk_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      q0_ff   <= q0_in;
      rem_ff  <= rem_in;
   end

   assign busy        = (cnt_ff != '0);
   assign block_count = nblk_ff;

endmodule

// File: hdl/uf2bf_front.sv
module uf2bf_front #(
   parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::DEF_PAYLOAD_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_data_byte,
   output logic               req_stall,
   input  logic               hold,
   input  logic [31:0]        base_address,
   input  logic [31:0]        total_bytes,
   output logic               push,
   output uf2bf_pkg::cmd_type cmd
);
   import uf2bf_pkg::*;

   localparam int unsigned PO_W = $clog2(PAYLOAD_BYTES);

   logic [PO_W-1:0]     po_ff, po_in;
   logic [BLKNUM_W-1:0] blk_ff, blk_in;
   logic [31:0]         off_ff, off_in;
   logic [31:0]         taken_ff, taken_in;
   logic                take, live, close;

   assign req_stall = hold;
   assign take      = req_valid && !hold;
   assign live      = (taken_ff < total_bytes);
   assign push      = take && live;

   always_comb begin
      cmd.data = req_data_byte;
      cmd.hdr  = (po_ff == '0);
      cmd.last = ((taken_ff + 32'd1) == total_bytes);
      cmd.pad  = (po_ff == PO_W'(PAYLOAD_BYTES - 1)) || cmd.last;
      cmd.pos  = POS_W'(HEADER_BYTES) + POS_W'(po_ff);
      cmd.blk  = blk_ff;
      cmd.addr = base_address + off_ff;
   end

   assign close = push && cmd.pad;

   always_comb begin
      po_in    = po_ff;
      blk_in   = blk_ff;
      off_in   = off_ff;
      taken_in = taken_ff;
      if (push) begin
         taken_in = taken_ff + 32'd1;
         po_in    = po_ff + PO_W'(1);
      end
      if (close) begin
         po_in  = '0;
         blk_in = blk_ff + BLKNUM_W'(1);
         // The address offset follows the 24-bit block number, wrap included.
         off_in = (blk_ff == '1) ? 32'd0 : off_ff + 32'(PAYLOAD_BYTES);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         po_ff    <= '0;
         blk_ff   <= '0;
         off_ff   <= '0;
         taken_ff <= '0;
      end else begin
         po_ff    <= po_in;
         blk_ff   <= blk_in;
         off_ff   <= off_in;
         taken_ff <= taken_in;
      end
   end

endmodule

// File: hdl/uf2bf_queue.sv
module uf2bf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  uf2bf_pkg::cmd_type cmd_in,
   input  logic               pop,
   output uf2bf_pkg::cmd_type head,
   output logic               empty,
   output logic               full
);
   import uf2bf_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= cmd_in;
      end
   end

   assign head  = mem_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));

endmodule

// File: hdl/uf2bf_back.sv
module uf2bf_back #(
   parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::DEF_PAYLOAD_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   input  uf2bf_pkg::cmd_type head,
   input  logic               head_valid,
   input  logic [31:0]        family_id,
   input  logic [31:0]        block_count,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_out_word,
   output logic               rsp_block_end,
   output logic               rsp_stream_end,
   output logic               rsp_run_last
);
   import uf2bf_pkg::*;

   localparam logic [1:0] PH_NEW = 2'd0;
   localparam logic [1:0] PH_HDR = 2'd1;
   localparam logic [1:0] PH_PAD = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [1:0]        hcnt_ff, hcnt_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic [55:0]       part_ff, part_in;
   logic              valid_ff, valid_in;
   logic [63:0]       word_ff, word_in;
   logic              be_ff, be_in;
   logic              se_ff, se_in;
   logic              rl_ff, rl_in;

   logic              out_free, step, emit, do_byte;
   logic [2:0]        lane;
   logic [55:0]       base_part;
   logic [63:0]       placed;
   logic [63:0]       hdr_word;

   assign out_free = !valid_ff || !rsp_stall;
   assign step     = head_valid && out_free;
   assign lane     = head.pos[2:0];
   // A header always opens a fresh word, so its byte lands on an empty one.
   assign base_part = (phase_ff == PH_HDR) ? 56'd0 : part_ff;
   assign placed    = {8'h00, base_part} | (64'(head.data) << {lane, 3'b000});

   always_comb begin
      unique case (hcnt_ff)
         2'd0:    hdr_word = {SIG_START_B, SIG_START_A};
         2'd1:    hdr_word = {head.addr, FLAG_FAMILY};
         2'd2:    hdr_word = {8'h00, head.blk, 32'(PAYLOAD_BYTES)};
         default: hdr_word = {family_id, block_count};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      hcnt_in  = hcnt_ff;
      widx_in  = widx_ff;
      part_in  = part_ff;
      emit     = 1'b0;
      pop      = 1'b0;
      do_byte  = 1'b0;
      word_in  = word_ff;
      be_in    = 1'b0;
      se_in    = 1'b0;
      rl_in    = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_NEW: begin
               if (head.hdr) begin
                  emit     = 1'b1;
                  word_in  = hdr_word;
                  hcnt_in  = 2'd1;
                  phase_in = PH_HDR;
               end else begin
                  do_byte = 1'b1;
               end
            end
            PH_HDR: begin
               emit    = 1'b1;
               word_in = hdr_word;
               hcnt_in = hcnt_ff + 2'd1;
               if (hcnt_ff == 2'd3) begin
                  do_byte = 1'b1;
                  rl_in   = !head.pad;
               end
            end
            PH_PAD: begin
               emit = 1'b1;
               if (widx_ff == LAST_WIDX) begin
                  word_in  = {SIG_TRAILER, 32'd0};
                  be_in    = 1'b1;
                  se_in    = head.last;
                  rl_in    = 1'b1;
                  pop      = 1'b1;
                  phase_in = PH_NEW;
               end else begin
                  word_in = {8'h00, part_ff};
                  widx_in = widx_ff + WIDX_W'(1);
               end
               part_in = '0;
            end
            default: begin
               phase_in = PH_NEW;
            end
         endcase

         if (do_byte) begin
            if (lane == 3'd7) begin
               emit    = 1'b1;
               word_in = placed;
               rl_in   = !head.pad;
               part_in = '0;
               widx_in = head.pos[POS_W-1:3] + WIDX_W'(1);
            end else begin
               part_in = placed[55:0];
               widx_in = head.pos[POS_W-1:3];
            end
            if (head.pad) begin
               phase_in = PH_PAD;
            end else begin
               phase_in = PH_NEW;
               pop      = 1'b1;
            end
         end
      end

      if (out_free) begin
         valid_in = emit;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NEW;
         hcnt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         valid_ff <= valid_in;
      end
      widx_ff <= widx_in;
      part_ff <= (reset) ? 56'd0 : part_in;
      if (emit && out_free) begin
         word_ff <= word_in;
         be_ff   <= be_in;
         se_ff   <= se_in;
         rl_ff   <= rl_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_word   = word_ff;
   assign rsp_block_end  = be_ff;
   assign rsp_stream_end = se_ff;
   assign rsp_run_last   = rl_ff;

endmodule

// File: hdl/uf2_block_framer_top.sv
// UF2 block framer. Image bytes enter one per item on the req_ channel and
// leave as 512-byte UF2 blocks, one 64-bit little-endian word per item on the
// rsp_ channel. Payload bytes are taken at one per cycle unless req_stall
// holds them off; the back end emits at most one word per cycle, so a block
// costs four header words (the first byte is folded into the fourth) and,
// after its last byte, a padding word for each remaining position up to the
// end magic. A four-entry command queue between the byte front end and the
// word back end lets bytes keep arriving while header and padding words
// drain. Writing total_bytes starts a block count calculation by reciprocal
// multiplication that holds req_stall high while it runs. Registers sit at
// byte addresses 0 (family_id), 4 (base_address) and 8 (total_bytes); the user
// must write them only while the block is idle; the block does not enforce it.
module uf2_block_framer_top #(
   parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::DEF_PAYLOAD_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [uf2bf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [63:0]                     rsp_out_word,
   output logic                            rsp_block_end,
   output logic                            rsp_stream_end,
   output logic                            rsp_run_last
);
   import uf2bf_pkg::*;

   logic [31:0]          family_ff, family_in;
   logic [31:0]          base_ff, base_in;
   logic [31:0]          total_ff, total_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en, total_load;
   logic                 cnt_busy;
   logic [31:0]          block_count;
   logic                 q_full, q_empty, push, pop;
   cmd_type              cmd, head;

   assign pready     = 1'b1;
   assign reg_idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en      = psel && penable && pwrite && pready;
   assign total_load = wr_en && (reg_idx == REG_TOTAL);

   always_comb begin
      family_in = family_ff;
      base_in   = base_ff;
      total_in  = total_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_FAMILY: family_in = pwdata;
            REG_BASE:   base_in   = pwdata;
            REG_TOTAL:  total_in  = pwdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FAMILY: prdata = family_ff;
         REG_BASE:   prdata = base_ff;
         REG_TOTAL:  prdata = total_ff;
         default:    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff <= '0;
         base_ff   <= '0;
         total_ff  <= '0;
      end else begin
         family_ff <= family_in;
         base_ff   <= base_in;
         total_ff  <= total_in;
      end
   end

   uf2bf_blkcnt #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_blkcnt (
      .clock       (clock),
      .reset       (reset),
      .load        (total_load),
      .total_bytes (pwdata),
      .busy        (cnt_busy),
      .block_count (block_count)
   );

   uf2bf_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .hold          (q_full || cnt_busy),
      .base_address  (base_ff),
      .total_bytes   (total_ff),
      .push          (push),
      .cmd           (cmd)
   );

   uf2bf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .cmd_in (cmd),
      .pop    (pop),
      .head   (head),
      .empty  (q_empty),
      .full   (q_full)
   );

   uf2bf_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (!q_empty),
      .family_id      (family_ff),
      .block_count    (block_count),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_word   (rsp_out_word),
      .rsp_block_end  (rsp_block_end),
      .rsp_stream_end (rsp_stream_end),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

// File: hdl/uf2bf_checker.sv
module uf2bf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_out_word,
   input logic        rsp_block_end,
   input logic        rsp_stream_end,
   input logic        rsp_run_last
);
   import uf2bf_pkg::*;

   // A stalled result item keeps its word.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_word))
      else $error("stalled result word changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_block_end)
      else $error("stream end outside a block end");

   // The end magic closes every block and the byte that caused it.
   a_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_end |-> rsp_out_word[63:32] == SIG_TRAILER && rsp_run_last)
      else $error("block end without end magic or run end");

endmodule

bind uf2_block_framer_top uf2bf_checker u_checker (.*);

// File: bench/uf2_frame_checker.sv
module uf2_frame_checker #(
   parameter int unsigned PAYLOAD_BYTES = uf2bf_pkg::DEF_PAYLOAD_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic                             pready,
   input  logic [uf2bf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [63:0]                      rsp_out_word,
   input  logic                             rsp_block_end,
   input  logic                             rsp_stream_end,
   input  logic                             rsp_run_last,
   output int unsigned                      mismatches,
   output int unsigned                      words_pending,
   output int unsigned                      bytes_framed,
   output int unsigned                      words_checked
);
   import uf2bf_pkg::*;

   localparam int unsigned BLOCK_LEN = 512;
   localparam int unsigned TAIL_POS  = 508;

   typedef struct packed {
      logic [63:0] word;
      logic        blk_end;
      logic        strm_end;
      logic        run_last;
   } stream_word_type;

   logic [31:0]     family_reg;
   logic [31:0]     base_reg;
   logic [31:0]     total_reg;
   logic [8:0]      pay_off;
   logic [23:0]     blk_num;
   logic [31:0]     taken;
   logic [63:0]     partial;
   stream_word_type words_due[$];

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic push_word(input logic [63:0] w, input logic be, input logic se);
      stream_word_type e;
      e.word     = w;
      e.blk_end  = be;
      e.strm_end = se;
      e.run_last = 1'b0;
      words_due.push_back(e);
   endtask

   task automatic put_lane(input int unsigned pos, input logic [7:0] v, input logic closing);
      partial[8*(pos%8) +: 8] = v;
      if (pos % 8 == 7) begin
         push_word(partial, pos == BLOCK_LEN-1, closing && (pos == BLOCK_LEN-1));
         partial = '0;
      end
   endtask

   // Works out every stream word that one accepted image byte releases.
   task automatic frame_byte(input logic [7:0] b);
      int unsigned     first;
      int unsigned     pos;
      logic            closing;
      logic [32:0]     blocks;
      logic [31:0]     addr;
      stream_word_type tail;
      if (taken >= total_reg) return;
      first = words_due.size();
      if (pay_off == 0) begin
         partial = '0;
         blocks = ({1'b0, total_reg} + 33'(PAYLOAD_BYTES) - 33'd1) / 33'(PAYLOAD_BYTES);
         addr = base_reg + 32'(blk_num) * 32'(PAYLOAD_BYTES);
         push_word({SIG_START_B, SIG_START_A}, 1'b0, 1'b0);
         push_word({addr, FLAG_FAMILY}, 1'b0, 1'b0);
         push_word({8'h00, blk_num, 32'(PAYLOAD_BYTES)}, 1'b0, 1'b0);
         push_word({family_reg, blocks[31:0]}, 1'b0, 1'b0);
      end
      put_lane(HEADER_BYTES + pay_off, b, 1'b0);
      pay_off = pay_off + 9'd1;
      taken   = taken + 32'd1;
      closing = (taken == total_reg);
      if (pay_off >= PAYLOAD_BYTES || closing) begin
         for (pos = HEADER_BYTES + pay_off; pos < BLOCK_LEN; pos++) begin
            put_lane(pos, (pos >= TAIL_POS) ? SIG_TRAILER[8*(pos-TAIL_POS) +: 8] : 8'h00,
                     closing);
         end
         pay_off = '0;
         blk_num = blk_num + 24'd1;
         partial = '0;
      end
      if (words_due.size() > first) begin
         tail = words_due.pop_back();
         tail.run_last = 1'b1;
         words_due.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      stream_word_type want;
      if (reset) begin
         family_reg = '0;
         base_reg   = '0;
         total_reg  = '0;
         pay_off    = '0;
         blk_num    = '0;
         taken      = '0;
         partial    = '0;
         words_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_FAMILY: family_reg = pwdata;
               REG_BASE:   base_reg   = pwdata;
               REG_TOTAL:  total_reg  = pwdata;
               default:    ;
            endcase
         end
         if (req_valid && !req_stall) begin
            frame_byte(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               note_mismatch("word with nothing expected", rsp_out_word, 64'd0);
            end else begin
               want = words_due.pop_front();
               if (rsp_out_word !== want.word) begin
                  note_mismatch("out_word", rsp_out_word, want.word);
               end
               if (rsp_block_end !== want.blk_end) begin
                  note_mismatch("block_end", 64'(rsp_block_end), 64'(want.blk_end));
               end
               if (rsp_stream_end !== want.strm_end) begin
                  note_mismatch("stream_end", 64'(rsp_stream_end), 64'(want.strm_end));
               end
               if (rsp_run_last !== want.run_last) begin
                  note_mismatch("run_last", 64'(rsp_run_last), 64'(want.run_last));
               end
            end
            words_checked++;
         end
      end
      words_pending = words_due.size();
      bytes_framed  = taken;
   end

endmodule

// File: bench/uf2_block_framer_top_tb.sv
module uf2_block_framer_top_tb;
   import uf2bf_pkg::*;

   localparam int unsigned PAYLOAD = DEF_PAYLOAD_BYTES;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr         = '0;
   logic [31:0]           pwdata        = '0;
   logic [31:0]           prdata;
   logic                  pready;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [63:0]           rsp_out_word;
   logic                  rsp_block_end;
   logic                  rsp_stream_end;
   logic                  rsp_run_last;

   int unsigned mismatches;
   int unsigned words_pending;
   int unsigned bytes_framed;
   int unsigned words_checked;
   int unsigned bytes_offered = 0;
   int unsigned settings      = 0;

   logic calm     = 1'b0;
   logic squeeze  = 1'b0;
   logic squeezed = 1'b0;

   always #1 clock = ~clock;

   uf2_block_framer_top #(.PAYLOAD_BYTES(PAYLOAD)) dut (.*);

   uf2_frame_checker #(.PAYLOAD_BYTES(PAYLOAD)) u_frame_check (.*);

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings++;
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken,
   // with valid still high so the next item can follow without a gap.
   task automatic push_byte(input logic [7:0] b);
      while (!calm && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_offered++;
   endtask

   task automatic feed_random(input int unsigned count);
      repeat (count) push_byte(8'($urandom_range(0, 255)));
   endtask

   // Drops valid, waits for every expected word, then lets the tail of the
   // block's pipeline run out before anything is reconfigured.
   task automatic settle();
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off so the framer backs up.
   initial begin
      forever begin
         @(negedge clock);
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 23);
      end
   end

   initial begin
      #2_000_000;
      $display("FAIL uf2_block_framer_top");
      $finish;
   end

   initial begin
      logic [7:0]  pattern [9];
      int unsigned len;
      pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h3C};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // An empty image takes nothing.
      push_byte(8'h00);
      push_byte(8'hFF);
      settle();

      // A one-byte image, then a byte past its end.
      csr_write(REG_FAMILY, 32'hFFFF_FFFF);
      csr_write(REG_BASE, 32'hFFFF_FF80);
      csr_write(REG_TOTAL, 32'd1);
      push_byte(8'hFF);
      push_byte(8'h00);
      settle();

      // The second block's address wraps past the top of the address space.
      csr_write(REG_FAMILY, 32'h0000_0000);
      csr_write(REG_TOTAL, 32'd10);
      foreach (pattern[i]) push_byte(pattern[i]);
      settle();

      // Leave a block open, cut the total below what was taken, then resume it.
      csr_write(REG_BASE, 32'hFFFF_FFFF);
      csr_write(REG_TOTAL, 32'd30);
      feed_random(5);
      settle();
      csr_write(REG_TOTAL, 32'd3);
      feed_random(2);
      settle();
      csr_write(REG_TOTAL, 32'd18);
      feed_random(3);
      settle();

      // A huge image fills a whole payload and stays open. The first stretch runs
      // with no idling on either side, then the output holds off for a long while.
      csr_write(REG_FAMILY, $urandom);
      csr_write(REG_BASE, $urandom);
      csr_write(REG_TOTAL, 32'hFFFF_FFFF);
      calm = 1'b1;
      feed_random(100);
      calm    = 1'b0;
      squeeze = 1'b1;
      feed_random(PAYLOAD + 1 - 100);
      settle();

      for (int phase = 1; phase <= 2; phase++) begin
         len = $urandom_range(1, 12);
         csr_write(REG_FAMILY, pick_value());
         csr_write(REG_BASE, pick_value());
         csr_write(REG_TOTAL, bytes_framed + len);
         feed_random(len);
         feed_random($urandom_range(0, 2));
         settle();
      end

      $display("Run covered %0d bytes offered, %0d framed into blocks and %0d words checked,",
               bytes_offered, bytes_framed, words_checked);
      $display("over %0d register writes, with dropped bytes and a long output hold-off.",
               settings);
      if (mismatches == 0 && words_pending == 0) begin
         $display("PASS uf2_block_framer_top");
      end else begin
         $display("FAIL uf2_block_framer_top");
      end
      $finish;
   end

endmodule

// File: uf2_block_framer_top.f
hdl/uf2bf_pkg.sv
hdl/uf2bf_blkcnt.sv
hdl/uf2bf_front.sv
hdl/uf2bf_queue.sv
hdl/uf2bf_back.sv
hdl/uf2_block_framer_top.sv
hdl/uf2bf_checker.sv
bench/uf2_frame_checker.sv
bench/uf2_block_framer_top_tb.sv
